// File: rtl/ryc_pkg.sv
`default_nettype none

package ryc_pkg;

    // Line geometry
    localparam int MAX_WIDTH    = 4096;
    localparam int LINE_ENTRIES = (MAX_WIDTH + 1) / 2;
    localparam int COL_W        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int IDX_W        = (LINE_ENTRIES > 1) ? $clog2(LINE_ENTRIES) : 1;

    // Pixel and result widths
    localparam int PIX_W     = 8;
    localparam int CH_W      = 16;
    localparam int SUM_W     = 2 * CH_W;

    // Matrix arithmetic
    localparam int NUM_CH     = 3;
    localparam int COEF_W     = 16;
    localparam int COEF_ROW_W = NUM_CH * COEF_W;
    localparam int OFF_W      = 18;
    localparam int DEPTH_W    = 4;
    localparam int FRAC_W     = 8;
    localparam int PROD_W     = COEF_W + 2 * PIX_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    // bits kept after the shifts: 16 result bits plus two for the quarter
    localparam int TAP_W      = CH_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_ROW_W;

    localparam logic [COEF_ROW_W-1:0] COEF_LUMA_RST = 48'h0000_0000_0100;
    localparam logic [COEF_ROW_W-1:0] COEF_CB_RST   = 48'h0000_0100_0000;
    localparam logic [COEF_ROW_W-1:0] COEF_CR_RST   = 48'h0100_0000_0000;
    localparam logic [DEPTH_W-1:0]    DEPTH_RST     = 4'd6;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_LUMA   = 3'd0,
        REG_COEF_CB     = 3'd1,
        REG_COEF_CR     = 3'd2,
        REG_OFFSET_LUMA = 3'd3,
        REG_OFFSET_CB   = 3'd4,
        REG_OFFSET_CR   = 3'd5,
        REG_DEPTH_SHIFT = 3'd6,
        REG_SUBSAMPLE   = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic [COEF_ROW_W-1:0]   coef_luma;
        logic [COEF_ROW_W-1:0]   coef_cb;
        logic [COEF_ROW_W-1:0]   coef_cr;
        logic signed [OFF_W-1:0] off_luma;
        logic signed [OFF_W-1:0] off_cb;
        logic signed [OFF_W-1:0] off_cr;
        logic [DEPTH_W-1:0]      depth_shift;
        logic                    subsample_420;
    } t_cfg;

    // Per-item chroma control, decided at input transfer
    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             clear_sum;
        logic             emit;
        logic             mode420;
    } t_item_ctl;

endpackage

`default_nettype wire

// File: rtl/ryc_pix_if.sv
`default_nettype none

interface ryc_pix_if import ryc_pkg::*;;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             row_end;
    logic             frame_start;
    logic             last_row;

    modport source (output valid, red, green, blue, row_end, frame_start, last_row,
                    input ready);
    modport sink (input valid, red, green, blue, row_end, frame_start, last_row,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/ryc_res_if.sv
`default_nettype none

interface ryc_res_if import ryc_pkg::*;;
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] luma;
    logic [CH_W-1:0] chroma_b;
    logic [CH_W-1:0] chroma_r;
    logic            chroma_valid;

    modport source (output valid, luma, chroma_b, chroma_r, chroma_valid, input ready);
    modport sink (input valid, luma, chroma_b, chroma_r, chroma_valid, output ready);
endinterface

`default_nettype wire

// File: rtl/ryc_cfg_if.sv
`default_nettype none

interface ryc_cfg_if import ryc_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/rgb_to_yuv_matrix_converter_unit.sv
`default_nettype none

// RGB to luma/chroma converter with a configurable 3x3 matrix.
// i_pix: one RGB pixel per transfer, with row_end, frame_start and last_row
//   marking the raster position. o_res: one result per pixel (luma, chroma_b,
//   chroma_r, chroma_valid). i_cfg: register writes, always ready; write only
//   while no pixel is in flight.
// Pipeline: input register (line buffer read), product register, result
//   register, which a result passes in that order; one pixel is taken every
//   cycle while the output is not stalled. The nine products take one stage;
//   the line buffer is read at input transfer and written as an item leaves stage 2.
// In 4:2:0 mode quarter-chroma values of each 2x2 block are summed in a
//   line buffer of MAX_WIDTH/2 entries; in-flight writes are forwarded so
//   back-to-back pixels of the same block see the updated sum.
// A stalled output only holds the result register; the two earlier stages
//   keep filling, so the input stays ready until all three are occupied.
// Reset clears the raster counters, the pipeline valid bits and loads the
//   register defaults; the line buffer is not cleared, each block's first
//   pixel overwrites its entry.
module rgb_to_yuv_matrix_converter_unit import ryc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ryc_pix_if.sink   i_pix,
    ryc_res_if.source o_res,
    ryc_cfg_if.sink   i_cfg
);

    t_cfg cfg;

    // raster position
    logic [COL_W-1:0] r_col;
    logic             r_odd;
    logic [COL_W-1:0] n_col;
    logic             n_odd;
    logic [COL_W-1:0] cur_col;
    logic             cur_odd;
    t_item_ctl        in_ctl;

    // stage 1: input register
    logic                          r_s1_valid;
    logic [NUM_CH-1:0][PIX_W-1:0]  r_s1_pix;
    t_item_ctl                     r_s1_ctl;
    logic                          r_s1_fwd_valid;
    logic [SUM_W-1:0]              r_s1_fwd_data;

    // stage 2: products
    logic             r_s2_valid;
    t_item_ctl        r_s2_ctl;
    logic [SUM_W-1:0] r_s2_old;

    // stage 3: result register
    logic            r_out_valid;
    logic [CH_W-1:0] r_out_luma;
    logic [CH_W-1:0] r_out_cb;
    logic [CH_W-1:0] r_out_cr;
    logic            r_out_cvalid;

    logic s3_free;
    logic s2_adv;
    logic s2_free;
    logic s1_adv;
    logic s1_free;
    logic in_xfer;

    logic [TAP_W-1:0] y_val;
    logic [TAP_W-1:0] cb_val;
    logic [TAP_W-1:0] cr_val;

    logic [SUM_W-1:0] ram_rd;
    logic             wr_en;
    logic [SUM_W-1:0] wr_data;
    logic [SUM_W-1:0] old_sum;
    logic [CH_W-1:0]  sum_b;
    logic [CH_W-1:0]  sum_r;
    logic [SUM_W-1:0] s2_old_next;

    ryc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // stage handshake
    assign s3_free     = !r_out_valid || o_res.ready;
    assign s2_adv      = r_s2_valid && s3_free;
    assign s2_free     = !r_s2_valid || s3_free;
    assign s1_adv      = r_s1_valid && s2_free;
    assign s1_free     = !r_s1_valid || s2_free;
    assign i_pix.ready = s1_free;
    assign in_xfer     = i_pix.valid && s1_free;

    // raster position of the incoming pixel and the one after it
    always_comb begin
        cur_col = i_pix.frame_start ? '0 : r_col;
        cur_odd = i_pix.frame_start ? 1'b0 : r_odd;

        in_ctl.idx       = IDX_W'(cur_col >> 1);
        in_ctl.clear_sum = !cur_col[0] && !cur_odd;
        in_ctl.emit      = (cur_odd || i_pix.last_row) && (cur_col[0] || i_pix.row_end);
        in_ctl.mode420   = cfg.subsample_420;

        if (i_pix.row_end) begin
            n_col = '0;
            n_odd = !cur_odd;
        end else begin
            n_col = (cur_col == COL_W'(MAX_WIDTH - 1)) ? '0 : cur_col + COL_W'(1);
            n_odd = cur_odd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_odd <= 1'b0;
        end else if (in_xfer) begin
            r_col <= n_col;
            r_odd <= n_odd;
        end
    end

    // chroma line buffer
    ryc_ram #(
        .WIDTH (SUM_W),
        .DEPTH (LINE_ENTRIES)
    ) u_line (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s2_ctl.idx),
        .i_wr_data (wr_data),
        .i_rd_en   (in_xfer),
        .i_rd_addr (in_ctl.idx),
        .o_rd_data (ram_rd)
    );

    // stage 1 register and forwarding of writes that land after the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid     <= 1'b0;
            r_s1_fwd_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid     <= 1'b1;
                r_s1_fwd_valid <= wr_en && (r_s2_ctl.idx == in_ctl.idx);
            end else begin
                if (s1_adv) begin
                    r_s1_valid <= 1'b0;
                end
                if (wr_en && (r_s2_ctl.idx == r_s1_ctl.idx)) begin
                    r_s1_fwd_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_pix      <= {i_pix.blue, i_pix.green, i_pix.red};
            r_s1_ctl      <= in_ctl;
            r_s1_fwd_data <= wr_data;
        end else if (wr_en && (r_s2_ctl.idx == r_s1_ctl.idx)) begin
            r_s1_fwd_data <= wr_data;
        end
    end

    // matrix rows, products registered at the stage 1 to 2 transfer
    ryc_row u_row_luma (
        .i_clk    (i_clk),
        .i_load   (s1_adv),
        .i_pix    (r_s1_pix),
        .i_coef   (cfg.coef_luma),
        .i_offset (cfg.off_luma),
        .i_depth  (cfg.depth_shift),
        .o_value  (y_val)
    );

    ryc_row u_row_cb (
        .i_clk    (i_clk),
        .i_load   (s1_adv),
        .i_pix    (r_s1_pix),
        .i_coef   (cfg.coef_cb),
        .i_offset (cfg.off_cb),
        .i_depth  (cfg.depth_shift),
        .o_value  (cb_val)
    );

    ryc_row u_row_cr (
        .i_clk    (i_clk),
        .i_load   (s1_adv),
        .i_pix    (r_s1_pix),
        .i_coef   (cfg.coef_cr),
        .i_offset (cfg.off_cr),
        .i_depth  (cfg.depth_shift),
        .o_value  (cr_val)
    );

    // newest sum for the entry: a write in this cycle, a forwarded one, or memory
    always_comb begin
        if (wr_en && (r_s2_ctl.idx == r_s1_ctl.idx)) begin
            s2_old_next = wr_data;
        end else if (r_s1_fwd_valid) begin
            s2_old_next = r_s1_fwd_data;
        end else begin
            s2_old_next = ram_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s2_valid <= 1'b1;
        end else if (s2_adv) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_s2_ctl <= r_s1_ctl;
            r_s2_old <= s2_old_next;
        end
    end

    // quarter-value accumulation, modulo 2^16
    always_comb begin
        old_sum = r_s2_ctl.clear_sum ? '0 : r_s2_old;
        sum_b   = old_sum[CH_W-1:0] + cb_val[TAP_W-1:2];
        sum_r   = old_sum[SUM_W-1:CH_W] + cr_val[TAP_W-1:2];
        wr_data = {sum_r, sum_b};
        wr_en   = s2_adv && r_s2_ctl.mode420;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out_luma <= y_val[CH_W-1:0];
            if (!r_s2_ctl.mode420) begin
                r_out_cb     <= cb_val[CH_W-1:0];
                r_out_cr     <= cr_val[CH_W-1:0];
                r_out_cvalid <= 1'b1;
            end else if (r_s2_ctl.emit) begin
                r_out_cb     <= sum_b;
                r_out_cr     <= sum_r;
                r_out_cvalid <= 1'b1;
            end else begin
                r_out_cb     <= '0;
                r_out_cr     <= '0;
                r_out_cvalid <= 1'b0;
            end
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.luma         = r_out_luma;
    assign o_res.chroma_b     = r_out_cb;
    assign o_res.chroma_r     = r_out_cr;
    assign o_res.chroma_valid = r_out_cvalid;

    // an empty result register must leave the input open
    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_pix.ready)
        else $error("input stalled with an empty result register");

    // a row end restarts the column count
    a_row_end_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_pix.row_end) |=> (r_col == '0))
        else $error("column count not cleared after row end");

    // a frame start places the next pixel at column one of an even row
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_pix.frame_start && !i_pix.row_end) |=> (r_col == COL_W'(1) && !r_odd))
        else $error("frame start did not reset the raster position");

    // the line buffer is only written by a 4:2:0 item leaving stage 2
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_s2_valid && s3_free && r_s2_ctl.mode420))
        else $error("line buffer written without a departing item");

endmodule

`default_nettype wire

// File: rtl/ryc_ram.sv
`default_nettype none

module ryc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/ryc_cfg_regs.sv
`default_nettype none

module ryc_cfg_regs import ryc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ryc_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                REG_COEF_LUMA:   n_cfg.coef_luma     = i_cfg.data;
                REG_COEF_CB:     n_cfg.coef_cb       = i_cfg.data;
                REG_COEF_CR:     n_cfg.coef_cr       = i_cfg.data;
                REG_OFFSET_LUMA: n_cfg.off_luma      = signed'(i_cfg.data[OFF_W-1:0]);
                REG_OFFSET_CB:   n_cfg.off_cb        = signed'(i_cfg.data[OFF_W-1:0]);
                REG_OFFSET_CR:   n_cfg.off_cr        = signed'(i_cfg.data[OFF_W-1:0]);
                REG_DEPTH_SHIFT: n_cfg.depth_shift   = i_cfg.data[DEPTH_W-1:0];
                REG_SUBSAMPLE:   n_cfg.subsample_420 = i_cfg.data[0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.coef_luma     <= COEF_LUMA_RST;
            r_cfg.coef_cb       <= COEF_CB_RST;
            r_cfg.coef_cr       <= COEF_CR_RST;
            r_cfg.off_luma      <= '0;
            r_cfg.off_cb        <= '0;
            r_cfg.off_cr        <= '0;
            r_cfg.depth_shift   <= DEPTH_RST;
            r_cfg.subsample_420 <= 1'b1;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// File: rtl/ryc_row.sv
`default_nettype none

// One matrix row: three registered products, then offset add and shifts.
module ryc_row import ryc_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_load,
    input  wire logic [NUM_CH-1:0][PIX_W-1:0]  i_pix,
    input  wire logic [COEF_ROW_W-1:0]         i_coef,
    input  wire logic signed [OFF_W-1:0]       i_offset,
    input  wire logic [DEPTH_W-1:0]            i_depth,
    output logic      [TAP_W-1:0]              o_value
);

    logic signed [PROD_W-1:0] r_prod [NUM_CH];
    logic signed [PROD_W-1:0] n_prod [NUM_CH];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  shifted;

    // channel widened by 0x101 (byte repeated), times signed 8.8 coefficient
    always_comb begin
        logic signed [PROD_W-1:0] c_ext;
        logic signed [PROD_W-1:0] x_ext;
        for (int k = 0; k < NUM_CH; k++) begin
            c_ext     = PROD_W'(signed'(i_coef[k*COEF_W +: COEF_W]));
            x_ext     = PROD_W'(signed'({1'b0, i_pix[k], i_pix[k]}));
            n_prod[k] = c_ext * x_ext;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod <= n_prod;
        end
    end

    // offset in output units sits above the fraction bits
    always_comb begin
        acc = (ACC_W'(i_offset) <<< FRAC_W)
            + ACC_W'(r_prod[0]) + ACC_W'(r_prod[1]) + ACC_W'(r_prod[2]);
        shifted = (acc >>> FRAC_W) >>> i_depth;
    end

    assign o_value = shifted[TAP_W-1:0];

endmodule

`default_nettype wire

// File: tb/sv/ryc_yuv_scoreboard.sv
`default_nettype none

// Watches the pixel, result and register channels, predicts each result
// from the observed pixel transfers and compares in order.
module ryc_yuv_scoreboard import ryc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    ryc_pix_if        pix,
    ryc_res_if        res,
    ryc_cfg_if        cfg,
    output int        o_pending,
    output int        o_errors
);

    typedef struct {
        logic [CH_W-1:0] luma;
        logic [CH_W-1:0] chroma_b;
        logic [CH_W-1:0] chroma_r;
        logic            chroma_valid;
    } t_yuv;

    // shadow registers and raster state
    t_cfg             regs;
    logic [COL_W-1:0] col_cnt;
    logic             odd_line;
    logic [SUM_W-1:0] chroma_line [LINE_ENTRIES];
    t_yuv             yuv_due [$];
    int               errs = 0;

    // one matrix row: offset plus weighted channels, then both shifts
    function automatic longint weigh_row(logic [COEF_ROW_W-1:0] row,
                                         logic signed [OFF_W-1:0] off,
                                         longint r, longint g, longint b);
        longint acc;
        acc = longint'(off) * 256
            + longint'($signed(row[15:0])) * r
            + longint'($signed(row[31:16])) * g
            + longint'($signed(row[47:32])) * b;
        return (acc >>> FRAC_W) >>> regs.depth_shift;
    endfunction

    task automatic predict_pixel();
        longint r, g, b, y, cb, cr, qb, qr;
        logic [IDX_W-1:0] idx;
        logic [SUM_W-1:0] old;
        logic [CH_W-1:0]  sb, sr;
        logic             odd_col;
        t_yuv             e;
        if (pix.frame_start) begin
            col_cnt  = '0;
            odd_line = 1'b0;
        end
        // widen 8-bit channels to 16 bits
        r  = longint'(pix.red) * 257;
        g  = longint'(pix.green) * 257;
        b  = longint'(pix.blue) * 257;
        y  = weigh_row(regs.coef_luma, regs.off_luma, r, g, b);
        cb = weigh_row(regs.coef_cb, regs.off_cb, r, g, b);
        cr = weigh_row(regs.coef_cr, regs.off_cr, r, g, b);
        e.luma = y[15:0];
        if (!regs.subsample_420) begin
            e.chroma_b     = cb[15:0];
            e.chroma_r     = cr[15:0];
            e.chroma_valid = 1'b1;
        end else begin
            // 2x2 block sum of quarter values; first pixel of a block overwrites
            idx     = IDX_W'(col_cnt >> 1);
            odd_col = col_cnt[0];
            old     = (!odd_col && !odd_line) ? '0 : chroma_line[idx];
            qb      = cb >>> 2;
            qr      = cr >>> 2;
            sb      = old[15:0] + qb[15:0];
            sr      = old[31:16] + qr[15:0];
            chroma_line[idx] = {sr, sb};
            if ((odd_line || pix.last_row) && (odd_col || pix.row_end)) begin
                e.chroma_b     = sb;
                e.chroma_r     = sr;
                e.chroma_valid = 1'b1;
            end else begin
                e.chroma_b     = '0;
                e.chroma_r     = '0;
                e.chroma_valid = 1'b0;
            end
        end
        // raster advance
        if (pix.row_end) begin
            col_cnt  = '0;
            odd_line = !odd_line;
        end else if (col_cnt == COL_W'(MAX_WIDTH - 1)) begin
            col_cnt = '0;
        end else begin
            col_cnt = col_cnt + 1'b1;
        end
        yuv_due.push_back(e);
    endtask

    function automatic void report(string field, int want, int got);
        errs++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction

    task automatic check_result();
        t_yuv e;
        if (yuv_due.size() == 0) begin
            errs++;
            $display("%0t: result with none expected, expected none, actual luma %h",
                     $time, res.luma);
        end else begin
            e = yuv_due.pop_front();
            if (res.luma !== e.luma) report("luma", e.luma, res.luma);
            if (res.chroma_b !== e.chroma_b) report("chroma_b", e.chroma_b, res.chroma_b);
            if (res.chroma_r !== e.chroma_r) report("chroma_r", e.chroma_r, res.chroma_r);
            if (res.chroma_valid !== e.chroma_valid)
                report("chroma_valid", e.chroma_valid, res.chroma_valid);
        end
    endtask

    // register write transfer
    task automatic apply_write();
        case (cfg.index)
            REG_COEF_LUMA:   regs.coef_luma     = cfg.data;
            REG_COEF_CB:     regs.coef_cb       = cfg.data;
            REG_COEF_CR:     regs.coef_cr       = cfg.data;
            REG_OFFSET_LUMA: regs.off_luma      = cfg.data[OFF_W-1:0];
            REG_OFFSET_CB:   regs.off_cb        = cfg.data[OFF_W-1:0];
            REG_OFFSET_CR:   regs.off_cr        = cfg.data[OFF_W-1:0];
            REG_DEPTH_SHIFT: regs.depth_shift   = cfg.data[DEPTH_W-1:0];
            REG_SUBSAMPLE:   regs.subsample_420 = cfg.data[0];
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.coef_luma     = COEF_LUMA_RST;
            regs.coef_cb       = COEF_CB_RST;
            regs.coef_cr       = COEF_CR_RST;
            regs.off_luma      = '0;
            regs.off_cb        = '0;
            regs.off_cr        = '0;
            regs.depth_shift   = DEPTH_RST;
            regs.subsample_420 = 1'b1;
            col_cnt            = '0;
            odd_line           = 1'b0;
            yuv_due.delete();
        end else begin
            if (res.valid && res.ready) check_result();
            if (cfg.valid && cfg.ready) apply_write();
            if (pix.valid && pix.ready) predict_pixel();
        end
        o_pending <= yuv_due.size();
        o_errors  <= errs;
    end

endmodule

`default_nettype wire

// File: tb/sv/rgb_to_yuv_matrix_converter_unit_test.sv
`default_nettype none

module rgb_to_yuv_matrix_converter_unit_test;
    import ryc_pkg::*;

    localparam int RANDOM_PIXELS = 700;
    localparam int LONG_ROW      = 200;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ryc_pix_if pix ();
    ryc_res_if res ();
    ryc_cfg_if cfg ();

    int fails;
    int due;

    // stimulus-side raster mirror, used only to keep buffer reads on written entries
    bit calm      = 1'b0;
    bit mode420   = 1'b1;
    int col_pos   = 0;
    bit odd_pos   = 1'b0;
    bit line_written [LINE_ENTRIES];
    int sent      = 0;

    always #1 i_clk = ~i_clk;

    rgb_to_yuv_matrix_converter_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    ryc_yuv_scoreboard sb (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .pix       (pix),
        .res       (res),
        .cfg       (cfg),
        .o_pending (due),
        .o_errors  (fails)
    );

    // result side back-pressure
    initial begin
        res.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            res.ready <= calm || ($urandom_range(99) >= 10);
        end
    end

    initial begin
        #2000000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        @(posedge i_clk);
        while (!cfg.ready) @(posedge i_clk);
        cfg.valid <= 1'b0;
        if (idx == REG_SUBSAMPLE) mode420 = value[0];
        @(posedge i_clk);
    endtask

    task automatic send_pixel(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
                              logic [PIX_W-1:0] b, bit re, bit fs, bit lr);
        int c;
        bit o;
        c = fs ? 0 : col_pos;
        o = fs ? 1'b0 : odd_pos;
        // a read of a never-written entry is turned into a frame start
        if (mode420 && (c[0] || o) && !line_written[c >> 1]) begin
            fs = 1'b1;
            c  = 0;
            o  = 1'b0;
        end
        if (mode420) line_written[c >> 1] = 1'b1;
        col_pos = re ? 0 : (c + 1) % MAX_WIDTH;
        odd_pos = re ? !o : o;
        while (!calm && $urandom_range(99) < 10) begin
            pix.valid <= 1'b0;
            @(posedge i_clk);
        end
        pix.valid       <= 1'b1;
        pix.red         <= r;
        pix.green       <= g;
        pix.blue        <= b;
        pix.row_end     <= re;
        pix.frame_start <= fs;
        pix.last_row    <= lr;
        sent++;
        @(posedge i_clk);
        while (!pix.ready) @(posedge i_clk);
    endtask

    // drop valid and wait until every predicted result has been taken
    task automatic settle();
        pix.valid <= 1'b0;
        @(posedge i_clk);
        while (due != 0) @(posedge i_clk);
    endtask

    task automatic send_frame(int width, int height, bit mark_last);
        for (int y = 0; y < height; y++) begin
            for (int x = 0; x < width; x++) begin
                send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                           x == width - 1, x == 0 && y == 0,
                           mark_last && y == height - 1);
            end
        end
    endtask

    function automatic logic [COEF_W-1:0] pick_coef();
        case ($urandom_range(3))
            0: return COEF_W'($urandom);
            1: return COEF_W'($urandom_range(1023)) - 16'd512;
            2: begin
                case ($urandom_range(3))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    default: return 16'hFFFF;
                endcase
            end
            default: begin
                case ($urandom_range(2))
                    0: return 16'h00DC;
                    1: return 16'h00E1;
                    default: return 16'h0100;
                endcase
            end
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_offset();
        logic [OFF_W-1:0] v;
        case ($urandom_range(3))
            0: v = '0;
            1: v = $urandom_range(1) ? 18'h08000 : 18'h01000;
            2: v = OFF_W'($urandom);
            default: v = $urandom_range(1) ? 18'h1FFFF : 18'h20000;
        endcase
        return CFG_DATA_W'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_depth();
        case ($urandom_range(3))
            0: return 48'd6;
            1: return 48'd0;
            2: return 48'd8;
            default: return CFG_DATA_W'($urandom_range(15));
        endcase
    endfunction

    task automatic load_random_setup();
        write_reg(REG_COEF_LUMA, {pick_coef(), pick_coef(), pick_coef()});
        write_reg(REG_COEF_CB, {pick_coef(), pick_coef(), pick_coef()});
        write_reg(REG_COEF_CR, {pick_coef(), pick_coef(), pick_coef()});
        write_reg(REG_OFFSET_LUMA, pick_offset());
        write_reg(REG_OFFSET_CB, pick_offset());
        write_reg(REG_OFFSET_CR, pick_offset());
        write_reg(REG_DEPTH_SHIFT, pick_depth());
        write_reg(REG_SUBSAMPLE, CFG_DATA_W'($urandom_range(1)));
    endtask

    initial begin
        int n;
        pix.valid       = 1'b0;
        pix.red         = '0;
        pix.green       = '0;
        pix.blue        = '0;
        pix.row_end     = 1'b0;
        pix.frame_start = 1'b0;
        pix.last_row    = 1'b0;
        cfg.valid       = 1'b0;
        cfg.index       = '0;
        cfg.data        = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset setup, 4:2:0: 2x3 frame with channel extremes, then a
        // one-row frame closed by last_row
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b1, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b1, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b1);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0, 1'b0, 1'b1);
        send_pixel(8'd128, 8'd127, 8'd1, 1'b1, 1'b0, 1'b1);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b1);
        send_pixel(8'd1, 8'd2, 8'd3, 1'b1, 1'b0, 1'b1);
        settle();

        // 4:4:4 with extreme coefficients, offsets and no depth shift
        write_reg(REG_COEF_LUMA, 48'h7FFF_7FFF_7FFF);
        write_reg(REG_COEF_CB, 48'h8000_8000_8000);
        write_reg(REG_COEF_CR, 48'h8000_7FFF_0001);
        write_reg(REG_OFFSET_LUMA, 48'h1FFFF);
        write_reg(REG_OFFSET_CB, 48'h20000);
        write_reg(REG_OFFSET_CR, 48'h08000);
        write_reg(REG_DEPTH_SHIFT, 48'd0);
        write_reg(REG_SUBSAMPLE, 48'd0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0, 1'b1, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd255, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b1, 1'b0, 1'b1);
        settle();

        // depth shift beyond the 8-bit range, back in 4:2:0
        write_reg(REG_DEPTH_SHIFT, 48'd15);
        write_reg(REG_OFFSET_LUMA, 48'h20000);
        write_reg(REG_SUBSAMPLE, 48'd1);
        send_frame(2, 2, 1'b1);
        settle();

        // typical matrix; one long row with no idling, then a short last row
        write_reg(REG_COEF_LUMA, 48'h001D_0096_004D);
        write_reg(REG_COEF_CB, 48'h0080_FFAB_FFD5);
        write_reg(REG_COEF_CR, 48'hFFEB_FF95_0080);
        write_reg(REG_OFFSET_LUMA, 48'h01000);
        write_reg(REG_OFFSET_CB, 48'h08000);
        write_reg(REG_DEPTH_SHIFT, 48'd8);
        calm = 1'b1;
        for (int i = 0; i < LONG_ROW; i++) begin
            send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                       i == LONG_ROW - 1, i == 0, 1'b0);
        end
        for (int i = 0; i < 4; i++) begin
            send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                       i == 3, 1'b0, 1'b1);
        end
        calm = 1'b0;
        settle();

        // random setups, mostly well-formed frames, some loose pixels
        while (sent < RANDOM_PIXELS) begin
            load_random_setup();
            repeat ($urandom_range(2, 4)) begin
                if ($urandom_range(9) == 0) begin
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        send_pixel(PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom),
                                   $urandom_range(3) == 0, $urandom_range(7) == 0,
                                   $urandom_range(2) == 0);
                    end
                end else begin
                    send_frame(($urandom_range(9) == 0) ? $urandom_range(10, 64)
                                                        : $urandom_range(1, 9),
                               $urandom_range(1, 5), $urandom_range(7) != 0);
                end
            end
            settle();
        end

        repeat (10) @(posedge i_clk);
        if (fails == 0 && due == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
